// File: rtl/core/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Types and codes shared by the keyed value table and its sub-blocks.
// ----------------------------------------------------------------------------
package kvt_pkg;

  // Snapshot results per transaction are capped at this count.
  localparam int MaxResults = 32;

  typedef enum logic [1:0] {
    KindPut      = 2'd0,
    KindGet      = 2'd1,
    KindForget   = 2'd2,
    KindSnapshot = 2'd3
  } kvt_kind_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusMiss  = 2'd2,
    StatusEmpty = 2'd3
  } kvt_status_e;

  typedef struct packed {
    kvt_kind_e          kind;
    logic [63:0]        node_key;
    logic [15:0]        endpoint_key;
    logic [31:0]        cluster_key;
    logic [31:0]        attribute_key;
    logic signed [63:0] write_value;
    logic [31:0]        now_seconds;
  } kvt_in_t;

  typedef struct packed {
    kvt_status_e        status;
    logic signed [63:0] read_value;
    logic [63:0]        entry_node;
    logic [15:0]        entry_endpoint;
    logic [31:0]        entry_cluster;
    logic [31:0]        entry_attribute;
    logic [31:0]        entry_time;
    logic               last;
  } kvt_out_t;

  // One stored table entry.
  typedef struct packed {
    logic [63:0]        node;
    logic [15:0]        endpoint;
    logic [31:0]        cluster;
    logic [31:0]        attribute;
    logic signed [63:0] value;
    logic [31:0]        stamp;
  } kvt_entry_t;

  // Key compare result of the shared match unit.
  typedef struct packed {
    logic node_hit;
    logic full_hit;
  } kvt_match_t;

endpackage

// File: rtl/core/keyed_value_table.sv
// ----------------------------------------------------------------------------
// keyed_value_table
// Associative table of keyed signed values with put, get, forget and snapshot.
// ----------------------------------------------------------------------------
// Every transaction walks the stored entries in order, one entry per cycle,
// through a single memory read port and one shared key match unit; a
// snapshot walk pauses while its result cannot enter the output register. A
// put or get stops early on a hit, a forget compacts the survivors in the
// same pass, and a snapshot emits one result per entry up to the result cap,
// one per cycle while the output is not stalled. Input is stalled for the
// whole of a transaction; the output register lets the last result wait
// while the next transaction is accepted. The registered memory read sets the
// walk: the address for entry i+1 is issued while entry i is compared.
// ----------------------------------------------------------------------------
module keyed_value_table #(
  parameter int ENTRY_COUNT = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kvt_pkg::kvt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kvt_pkg::kvt_out_t out_data_o
);

  localparam int AW       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CW       = $clog2(ENTRY_COUNT + 1);
  localparam int SnapMax  = (ENTRY_COUNT > kvt_pkg::MaxResults) ?
                            kvt_pkg::MaxResults : ENTRY_COUNT;

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SScan = 3'b010,
    SDone = 3'b100
  } state_e;

  state_e state_q, state_d;

  kvt_pkg::kvt_in_t req_q, req_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;   // next entry to read
  logic             dv_q, dv_d;           // read data holds a valid entry
  logic [AW-1:0]    dv_idx_q, dv_idx_d;   // index of that entry
  logic [CW-1:0]    wr_ptr_q, wr_ptr_d;   // compaction write pointer
  logic             hit_q, hit_d;
  logic [AW-1:0]    hit_idx_q, hit_idx_d;
  logic signed [63:0] hit_val_q, hit_val_d;

  logic              out_valid_q, out_valid_d;
  kvt_pkg::kvt_out_t out_q, out_d;

  // Memory and match unit hookup.
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  kvt_pkg::kvt_entry_t mem_wdata;
  logic                mem_re;
  kvt_pkg::kvt_entry_t mem_rdata;
  kvt_pkg::kvt_match_t match;

  // Walk control.
  logic          out_free;
  logic          proc;
  logic          is_lookup;
  logic          is_snap;
  logic          can_go;
  logic          stop_hit;
  logic [CW-1:0] lim;
  logic          out_push;
  kvt_pkg::kvt_out_t push_data;

  kvt_mem #(
    .ENTRY_COUNT(ENTRY_COUNT),
    .AW         (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(rd_idx_q[AW-1:0]),
    .rdata_o(mem_rdata)
  );

  kvt_cmp u_cmp (
    .entry_i(mem_rdata),
    .req_i  (req_q),
    .match_o(match)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != SIdle);
  assign is_lookup  = req_q.kind inside {kvt_pkg::KindPut, kvt_pkg::KindGet};
  assign is_snap    = (req_q.kind == kvt_pkg::KindSnapshot);
  assign proc       = (state_q == SScan) && dv_q;

  // Snapshot stops at the result cap; the other walks cover every entry unless a put or get hits first.
  always_comb begin
    lim = fill_q;
    if (is_snap && (fill_q > CW'(SnapMax))) begin
      lim = CW'(SnapMax);
    end
  end

  // Snapshot entries wait for a free output register.
  assign can_go   = !(proc && is_snap && !out_free);
  assign stop_hit = proc && is_lookup && match.full_hit;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    dv_d        = dv_q;
    dv_idx_d    = dv_idx_q;
    wr_ptr_d    = wr_ptr_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_val_d   = hit_val_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_ptr_q[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    out_push    = 1'b0;
    push_data   = '0;

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          rd_idx_d = '0;
          dv_d     = 1'b0;
          wr_ptr_d = '0;
          hit_d    = 1'b0;
          state_d  = SScan;
        end
      end

      SScan: begin
        // Process the entry in the read register.
        if (stop_hit) begin
          hit_d     = 1'b1;
          hit_idx_d = dv_idx_q;
          hit_val_d = mem_rdata.value;
        end
        if (proc && (req_q.kind == kvt_pkg::KindForget) && !match.node_hit) begin
          mem_we   = 1'b1;
          wr_ptr_d = wr_ptr_q + CW'(1);
        end
        if (proc && is_snap && out_free) begin
          out_push                 = 1'b1;
          push_data.status         = kvt_pkg::StatusOk;
          push_data.read_value     = mem_rdata.value;
          push_data.entry_node     = mem_rdata.node;
          push_data.entry_endpoint = mem_rdata.endpoint;
          push_data.entry_cluster  = mem_rdata.cluster;
          push_data.entry_attribute = mem_rdata.attribute;
          push_data.entry_time     = mem_rdata.stamp;
          push_data.last           = (CW'(dv_idx_q) + CW'(1) == lim);
        end

        // Advance the read side.
        if (can_go) begin
          if (!stop_hit && (rd_idx_q < lim)) begin
            mem_re   = 1'b1;
            rd_idx_d = rd_idx_q + CW'(1);
            dv_d     = 1'b1;
            dv_idx_d = rd_idx_q[AW-1:0];
          end else begin
            dv_d = 1'b0;
          end
          if (stop_hit || (rd_idx_q == lim)) begin
            if (req_q.kind == kvt_pkg::KindForget) begin
              fill_d = wr_ptr_d;
            end
            dv_d = 1'b0;
            // A non-empty snapshot has already sent its results.
            if (is_snap && (lim != '0)) begin
              state_d = SIdle;
            end else begin
              state_d = SDone;
            end
          end
        end
      end

      SDone: begin
        if (out_free) begin
          out_push       = 1'b1;
          push_data.last = 1'b1;
          state_d        = SIdle;
          case (req_q.kind)
            kvt_pkg::KindPut: begin
              mem_wdata.node      = req_q.node_key;
              mem_wdata.endpoint  = req_q.endpoint_key;
              mem_wdata.cluster   = req_q.cluster_key;
              mem_wdata.attribute = req_q.attribute_key;
              mem_wdata.value     = req_q.write_value;
              mem_wdata.stamp     = req_q.now_seconds;
              if (hit_q) begin
                mem_we           = 1'b1;
                mem_waddr        = hit_idx_q;
                push_data.status = kvt_pkg::StatusOk;
              end else if (fill_q != CW'(ENTRY_COUNT)) begin
                mem_we           = 1'b1;
                mem_waddr        = fill_q[AW-1:0];
                fill_d           = fill_q + CW'(1);
                push_data.status = kvt_pkg::StatusOk;
              end else begin
                push_data.status = kvt_pkg::StatusFull;
              end
            end
            kvt_pkg::KindGet: begin
              if (hit_q) begin
                push_data.status     = kvt_pkg::StatusOk;
                push_data.read_value = hit_val_q;
              end else begin
                push_data.status = kvt_pkg::StatusMiss;
              end
            end
            kvt_pkg::KindForget: begin
              push_data.status = kvt_pkg::StatusOk;
            end
            default: begin
              push_data.status = kvt_pkg::StatusEmpty;
            end
          endcase
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Output register: load on push, drop once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_push) begin
      out_valid_d = 1'b1;
      out_d       = push_data;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      fill_q      <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rd_idx_q  <= rd_idx_d;
    dv_idx_q  <= dv_idx_d;
    wr_ptr_q  <= wr_ptr_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    hit_val_q <= hit_val_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Fill count stays within the table.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(ENTRY_COUNT))
    else $error("fill count above table size");

  // Compaction never writes ahead of the read side.
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan) |-> (wr_ptr_q <= rd_idx_q))
    else $error("compaction pointer passed read pointer");

  // The entry in the read register is the one just before the read pointer.
  a_read_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q |-> (CW'(dv_idx_q) + CW'(1) == rd_idx_q))
    else $error("read data index out of step");

  // A recorded hit points at a live entry.
  a_hit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == SDone) && hit_q) |-> (CW'(hit_idx_q) < fill_q))
    else $error("hit index beyond fill count");

  // Every result is pushed only into a free output register.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(out_q) && out_valid_q))
    else $error("output register overwritten while stalled");

endmodule

// File: rtl/core/kvt_mem.sv
// ----------------------------------------------------------------------------
// kvt_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kvt_mem #(
  parameter int ENTRY_COUNT = 32,
  parameter int AW          = 5
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  kvt_pkg::kvt_entry_t wdata_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output kvt_pkg::kvt_entry_t rdata_o
);

  kvt_pkg::kvt_entry_t mem [ENTRY_COUNT];
  kvt_pkg::kvt_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/kvt_cmp.sv
// ----------------------------------------------------------------------------
// kvt_cmp
// Shared key match unit: compares one stored entry against the request key.
// ----------------------------------------------------------------------------
module kvt_cmp (
  input  kvt_pkg::kvt_entry_t entry_i,
  input  kvt_pkg::kvt_in_t    req_i,
  output kvt_pkg::kvt_match_t match_o
);

  logic node_eq;
  logic rest_eq;

  assign node_eq = (entry_i.node == req_i.node_key);
  assign rest_eq = (entry_i.endpoint == req_i.endpoint_key) &&
                   (entry_i.cluster == req_i.cluster_key) &&
                   (entry_i.attribute == req_i.attribute_key);

  assign match_o.node_hit = node_eq;
  assign match_o.full_hit = node_eq && rest_eq;

endmodule

// File: bench/keyed_value_table_tb.sv
// ----------------------------------------------------------------------------
// keyed_value_table_tb
// Self-checking bench for the keyed value table: a short directed table of
// puts, gets, forgets and snapshots, then pooled-key random traffic under
// four sender/receiver idling mixes, all checked field by field against
// hand-typed answers or an in-bench table predictor.
// ----------------------------------------------------------------------------
module keyed_value_table_tb;

  localparam int EntryCount    = 32;
  localparam int HalfPeriod    = 5;
  localparam int ResetCycles   = 9;
  localparam int WatchdogLimit = 1500;
  localparam int DrainCycles   = 40;
  localparam int PhaseCount    = 4;
  localparam int FillBurst     = 34;
  localparam int MixedPerPhase = 53;
  localparam int NodePool      = 8;
  localparam int EndpointPool  = 4;
  localparam int ClusterPool   = 3;
  localparam int AttributePool = 3;

  // One directed row: the transaction, plus a hand-typed result where the
  // answer is obvious (single result only); other rows use the predictor.
  typedef struct {
    kvt_pkg::kvt_in_t  item;
    bit                typed;
    kvt_pkg::kvt_out_t result;
  } stim_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  kvt_pkg::kvt_in_t  in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  kvt_pkg::kvt_out_t out_data_o;

  // Side-band for the directed rows, held alongside in_data_i.
  bit                row_typed   = 1'b0;
  kvt_pkg::kvt_out_t row_result  = '0;

  int       send_idle_pct = 0;
  int       stall_pct     = 0;
  int       idle_cycles   = 0;
  int       fault_count   = 0;

  logic     in_fire;
  logic     out_fire;

  // Shadow copy of the table, in insertion order.
  kvt_pkg::kvt_entry_t shadow_entries [EntryCount];
  int unsigned         shadow_fill = 0;

  kvt_pkg::kvt_out_t fresh_results   [$];
  kvt_pkg::kvt_out_t pending_results [$];
  stim_row_t         directed_rows   [$];

  logic [63:0] node_pool      [NodePool];
  logic [15:0] endpoint_pool  [EndpointPool];
  logic [31:0] cluster_pool   [ClusterPool];
  logic [31:0] attribute_pool [AttributePool];

  keyed_value_table #(
    .ENTRY_COUNT (EntryCount)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;

  // ---------------------------------------------------------------------------
  // Queue helpers
  // ---------------------------------------------------------------------------

  function automatic void add_fresh(input kvt_pkg::kvt_out_t res);
    fresh_results = {fresh_results, res};
  endfunction

  function automatic void add_pending(input kvt_pkg::kvt_out_t res);
    pending_results = {pending_results, res};
  endfunction

  function automatic void add_row(input stim_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------

  // Return the slot holding the full four-part key, or -1.
  function automatic int find_entry(input kvt_pkg::kvt_in_t item);
    for (int i = 0; i < shadow_fill; i++) begin
      if (shadow_entries[i].node == item.node_key &&
          shadow_entries[i].endpoint == item.endpoint_key &&
          shadow_entries[i].cluster == item.cluster_key &&
          shadow_entries[i].attribute == item.attribute_key) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Apply one transaction to the shadow table and leave its results in
  // fresh_results, in the order the block must emit them.
  function automatic void predict_table_response(input kvt_pkg::kvt_in_t item);
    kvt_pkg::kvt_out_t res;
    int                hit;
    int                kept;
    int                count;
    fresh_results.delete();
    res      = '0;
    res.last = 1'b1;
    case (item.kind)
      kvt_pkg::KindPut: begin
        hit = find_entry(item);
        if (hit < 0 && shadow_fill >= EntryCount) begin
          res.status = kvt_pkg::StatusFull;
        end else begin
          if (hit < 0) begin
            hit = shadow_fill;
            shadow_entries[hit].node      = item.node_key;
            shadow_entries[hit].endpoint  = item.endpoint_key;
            shadow_entries[hit].cluster   = item.cluster_key;
            shadow_entries[hit].attribute = item.attribute_key;
            shadow_fill++;
          end
          shadow_entries[hit].value = item.write_value;
          shadow_entries[hit].stamp = item.now_seconds;
          res.status = kvt_pkg::StatusOk;
        end
        add_fresh(res);
      end
      kvt_pkg::KindGet: begin
        hit = find_entry(item);
        if (hit < 0) begin
          res.status = kvt_pkg::StatusMiss;
        end else begin
          res.status     = kvt_pkg::StatusOk;
          res.read_value = shadow_entries[hit].value;
        end
        add_fresh(res);
      end
      kvt_pkg::KindForget: begin
        // Drop every entry of the node, slide survivors down in order.
        kept = 0;
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_entries[i].node != item.node_key) begin
            shadow_entries[kept] = shadow_entries[i];
            kept++;
          end
        end
        shadow_fill = kept;
        res.status  = kvt_pkg::StatusOk;
        add_fresh(res);
      end
      default: begin
        count = (shadow_fill > kvt_pkg::MaxResults) ? kvt_pkg::MaxResults : shadow_fill;
        if (count == 0) begin
          res.status = kvt_pkg::StatusEmpty;
          add_fresh(res);
        end else begin
          for (int i = 0; i < count; i++) begin
            res.status          = kvt_pkg::StatusOk;
            res.read_value      = shadow_entries[i].value;
            res.entry_node      = shadow_entries[i].node;
            res.entry_endpoint  = shadow_entries[i].endpoint;
            res.entry_cluster   = shadow_entries[i].cluster;
            res.entry_attribute = shadow_entries[i].attribute;
            res.entry_time      = shadow_entries[i].stamp;
            res.last            = (i == count - 1);
            add_fresh(res);
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void flag_field(input string field, input logic [63:0] want,
                                     input logic [63:0] got);
    fault_count++;
    $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
  endfunction

  // Compare one accepted result against the oldest expectation.
  function automatic void check_result(input kvt_pkg::kvt_out_t got);
    kvt_pkg::kvt_out_t want;
    if (pending_results.size() == 0) begin
      fault_count++;
      $display("%0t: result with nothing expected: expected none, got %p", $time, got);
      return;
    end
    want = pending_results.pop_front();
    if (got.status !== want.status) flag_field("status", want.status, got.status);
    if (got.read_value !== want.read_value) begin
      flag_field("read_value", want.read_value, got.read_value);
    end
    if (got.entry_node !== want.entry_node) begin
      flag_field("entry_node", want.entry_node, got.entry_node);
    end
    if (got.entry_endpoint !== want.entry_endpoint) begin
      flag_field("entry_endpoint", want.entry_endpoint, got.entry_endpoint);
    end
    if (got.entry_cluster !== want.entry_cluster) begin
      flag_field("entry_cluster", want.entry_cluster, got.entry_cluster);
    end
    if (got.entry_attribute !== want.entry_attribute) begin
      flag_field("entry_attribute", want.entry_attribute, got.entry_attribute);
    end
    if (got.entry_time !== want.entry_time) begin
      flag_field("entry_time", want.entry_time, got.entry_time);
    end
    if (got.last !== want.last) flag_field("last", want.last, got.last);
  endfunction

  // Sample both channels at the rising edge. Predict on every accepted input
  // transaction; directed rows with a typed answer replace the prediction but
  // still advance the shadow table.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        predict_table_response(in_data_i);
        if (row_typed) begin
          add_pending(row_result);
        end else begin
          foreach (fresh_results[k]) add_pending(fresh_results[k]);
        end
      end
      if (out_fire) check_result(out_data_o);
      idle_cycles <= (in_fire || out_fire) ? 0 : idle_cycles + 1;
    end
  end

  // Receiver: stall at the current rate, one decision per falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic stim_row_t make_row(input kvt_pkg::kvt_kind_e kind,
                                         input logic [63:0] node,
                                         input logic [15:0] endpoint,
                                         input logic [31:0] cluster,
                                         input logic [31:0] attribute,
                                         input logic [63:0] value,
                                         input logic [31:0] now, input bit typed,
                                         input kvt_pkg::kvt_status_e status,
                                         input logic [63:0] read_value);
    stim_row_t row;
    row.item.kind           = kind;
    row.item.node_key       = node;
    row.item.endpoint_key   = endpoint;
    row.item.cluster_key    = cluster;
    row.item.attribute_key  = attribute;
    row.item.write_value    = value;
    row.item.now_seconds    = now;
    row.typed               = typed;
    row.result              = '0;
    row.result.status       = status;
    row.result.read_value   = read_value;
    row.result.last         = 1'b1;
    return row;
  endfunction

  // Random transaction with keys drawn mostly from small pools so that puts
  // overwrite, gets hit and forgets find entries; a tenth of the keys are noise.
  function automatic kvt_pkg::kvt_in_t random_transaction(input kvt_pkg::kvt_kind_e kind);
    kvt_pkg::kvt_in_t item;
    item.kind = kind;
    item.node_key = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                              : node_pool[$urandom_range(NodePool - 1)];
    item.endpoint_key = ($urandom_range(9) == 0) ? 16'($urandom)
                        : endpoint_pool[$urandom_range(EndpointPool - 1)];
    item.cluster_key = ($urandom_range(9) == 0) ? $urandom
                       : cluster_pool[$urandom_range(ClusterPool - 1)];
    item.attribute_key = ($urandom_range(9) == 0) ? $urandom
                         : attribute_pool[$urandom_range(AttributePool - 1)];
    item.write_value = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       item.now_seconds = '0;
      1:       item.now_seconds = '1;
      default: item.now_seconds = $urandom;
    endcase
    return item;
  endfunction

  function automatic kvt_pkg::kvt_kind_e random_kind();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return kvt_pkg::KindPut;
    if (pick < 75) return kvt_pkg::KindGet;
    if (pick < 82) return kvt_pkg::KindForget;
    return kvt_pkg::KindSnapshot;
  endfunction

  // Offer one transaction. Entered and left right after a falling edge; hold
  // the payload until the block takes it.
  task automatic offer_transaction(input kvt_pkg::kvt_in_t item, input bit typed,
                                   input kvt_pkg::kvt_out_t result);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    row_typed  <= typed;
    row_result <= result;
    do @(posedge clk_i); while (in_fire !== 1'b1);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every expected result has drained.
  task automatic drain_pending();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // Timeout: nothing accepted on either side for too long.
  initial begin
    wait (rst_ni === 1'b1);
    wait (idle_cycles >= WatchdogLimit);
    $display("keyed_value_table regression: fail");
    $finish;
  end

  initial begin
    logic [63:0] ones64;
    logic [63:0] min64;
    logic [63:0] max64;
    ones64 = '1;
    min64  = 64'h8000_0000_0000_0000;
    max64  = 64'h7FFF_FFFF_FFFF_FFFF;

    // Key pools: all-zero and all-one members cover every key bit.
    node_pool[0] = '0;
    node_pool[1] = '1;
    for (int i = 2; i < NodePool; i++) node_pool[i] = {$urandom, $urandom};
    endpoint_pool[0] = '0;
    endpoint_pool[1] = '1;
    for (int i = 2; i < EndpointPool; i++) endpoint_pool[i] = 16'($urandom);
    cluster_pool[0]   = '0;
    cluster_pool[1]   = '1;
    cluster_pool[2]   = $urandom;
    attribute_pool[0] = '0;
    attribute_pool[1] = '1;
    attribute_pool[2] = $urandom;

    // Directed table. Typed rows carry the obvious answer; the rest are left
    // to the predictor (multi-entry snapshots, plain stores).
    add_row(make_row(kvt_pkg::KindSnapshot, 0, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusEmpty, 0));
    add_row(make_row(kvt_pkg::KindGet, 0, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusMiss, 0));
    add_row(make_row(kvt_pkg::KindForget, 0, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindPut, 0, 0, 0, 0, min64, 0, 1, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindPut, ones64, 16'hFFFF, '1, '1, max64, '1,
                     1, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindGet, 0, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusOk, min64));
    add_row(make_row(kvt_pkg::KindGet, ones64, 16'hFFFF, '1, '1, 0, 0,
                     1, kvt_pkg::StatusOk, max64));
    // Partial key matches must miss.
    add_row(make_row(kvt_pkg::KindGet, ones64, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusMiss, 0));
    add_row(make_row(kvt_pkg::KindGet, 0, 16'hFFFF, 0, 0, 0, 0, 1, kvt_pkg::StatusMiss, 0));
    add_row(make_row(kvt_pkg::KindGet, 0, 0, 0, '1, 0, 0, 1, kvt_pkg::StatusMiss, 0));
    // Overwrite in place.
    add_row(make_row(kvt_pkg::KindPut, 0, 0, 0, 0, ones64, 32'd123, 1,
                     kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindGet, 0, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusOk, ones64));
    add_row(make_row(kvt_pkg::KindSnapshot, 0, 0, 0, 0, 0, 0, 0, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindPut, 5, 1, 2, 3, 10, 100, 0, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindPut, 5, 2, 2, 3, 20, 200, 0, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindPut, 9, 1, 2, 3, -30, 300, 0, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindPut, 5, 3, 2, 3, 40, 400, 0, kvt_pkg::StatusOk, 0));
    // Forget a node spread across the table, then check order is kept.
    add_row(make_row(kvt_pkg::KindForget, 5, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindSnapshot, 0, 0, 0, 0, 0, 0, 0, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindGet, 5, 1, 2, 3, 0, 0, 1, kvt_pkg::StatusMiss, 0));
    add_row(make_row(kvt_pkg::KindForget, ones64, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindSnapshot, 0, 0, 0, 0, 0, 0, 0, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindForget, 0, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindForget, 9, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusOk, 0));
    add_row(make_row(kvt_pkg::KindSnapshot, 0, 0, 0, 0, 0, 0, 1, kvt_pkg::StatusEmpty, 0));

    // Reset once, release on a falling edge.
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      offer_transaction(directed_rows[r].item, directed_rows[r].typed,
                        directed_rows[r].result);
    end

    // Random phases: no idling, sender idle, receiver stalling, both. Each
    // starts from a drained block, fills the table past full, then mixes.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain_pending();
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 48; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 48; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      for (int i = 0; i < FillBurst; i++) begin
        offer_transaction(random_transaction(kvt_pkg::KindPut), 1'b0, '0);
      end
      for (int i = 0; i < MixedPerPhase; i++) begin
        offer_transaction(random_transaction(random_kind()), 1'b0, '0);
      end
    end

    // Let everything drain, then give the block time to show strays.
    drain_pending();
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("keyed_value_table regression: pass");
    end else begin
      $display("keyed_value_table regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/kvt_pkg.sv
rtl/core/kvt_mem.sv
rtl/core/kvt_cmp.sv
rtl/core/keyed_value_table.sv
bench/keyed_value_table_tb.sv
